>>> rtl/core/clbs_pkg.sv
package clbs_pkg;

  // Request kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_POS   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // Register indexes on the configuration port.
  localparam logic REG_BUS_8BIT  = 1'b0;
  localparam logic REG_TWO_LINE  = 1'b1;
  localparam int   PADDR_W       = 3;

  // Timing constants in microseconds.
  localparam logic [15:0] BYTE_WAIT    = 16'd50;
  localparam logic [15:0] WAIT_1000    = 16'd1000;
  localparam logic [15:0] WAIT_20000   = 16'd20000;
  localparam logic [15:0] POWERUP_WAIT = 16'd60000;

  // Microprogram layout.
  localparam int          PROG_LEN = 17;
  localparam int          PC_W     = $clog2(PROG_LEN);
  localparam logic [PC_W-1:0] PC_INIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_WRITE = PC_W'(15);
  localparam logic [PC_W-1:0] PC_POS   = PC_W'(16);

  typedef struct packed {
    logic [1:0] kind;
    logic       register_select;
    logic [7:0] byte_value;
    logic [1:0] line_index;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic        strobe_res;
    logic        rs_level;
    logic [7:0]  bus_value;
    logic [15:0] wait_us;
    logic        last;
  } out_item_t;

  // Event kind of one microinstruction.
  typedef enum logic [1:0] {
    OP_WAIT = 2'd0,   // pure wait, no strobe
    OP_RAW  = 2'd1,   // one strobe of the constant, no byte wait
    OP_BYTE = 2'd2    // whole byte or nibble pair, then the byte wait
  } op_e;

  // Where the byte of an OP_BYTE step comes from.
  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_DATA  = 2'd1,  // request data latched at accept
    SRC_FSET  = 2'd2   // function-set command, depends on configuration
  } src_e;

  // Extra hold-off after the step.
  typedef enum logic [2:0] {
    W_NONE    = 3'd0,
    W_1000    = 3'd1,
    W_20000   = 3'd2,
    W_60000   = 3'd3,
    W_1000_N4 = 3'd4   // 1000 only on the four-bit bus
  } wsel_e;

  // Sequencing after the step.
  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_IF8    = 2'd2,
    JMP_END    = 2'd3
  } jmp_e;

  typedef struct packed {
    op_e             op;
    src_e            src;
    logic [7:0]      konst;
    wsel_e           wsel;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] T_NONE = PC_W'(0);

  // Control store.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t cw;
    unique case (pc)
      // Init: power-up wait, then the four-bit wake-up nibbles.
      PC_W'(0):  cw = '{OP_WAIT, SRC_CONST, 8'h00, W_60000, JMP_IF8, PC_W'(6)};
      PC_W'(1):  cw = '{OP_RAW,  SRC_CONST, 8'h30, W_20000, JMP_NEXT, T_NONE};
      PC_W'(2):  cw = '{OP_RAW,  SRC_CONST, 8'h30, W_1000,  JMP_NEXT, T_NONE};
      PC_W'(3):  cw = '{OP_RAW,  SRC_CONST, 8'h30, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(4):  cw = '{OP_RAW,  SRC_CONST, 8'h20, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(5):  cw = '{OP_BYTE, SRC_FSET,  8'h00, W_NONE,  JMP_ALWAYS, PC_W'(10)};
      // Eight-bit wake-up bytes.
      PC_W'(6):  cw = '{OP_BYTE, SRC_CONST, 8'h30, W_20000, JMP_NEXT, T_NONE};
      PC_W'(7):  cw = '{OP_BYTE, SRC_CONST, 8'h30, W_1000,  JMP_NEXT, T_NONE};
      PC_W'(8):  cw = '{OP_BYTE, SRC_CONST, 8'h30, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(9):  cw = '{OP_BYTE, SRC_FSET,  8'h00, W_NONE,  JMP_NEXT, T_NONE};
      // Common tail of init.
      PC_W'(10): cw = '{OP_BYTE, SRC_CONST, 8'h14, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(11): cw = '{OP_BYTE, SRC_CONST, 8'h0C, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(12): cw = '{OP_BYTE, SRC_CONST, 8'h06, W_1000,  JMP_NEXT, T_NONE};
      PC_W'(13): cw = '{OP_BYTE, SRC_CONST, 8'h01, W_NONE,  JMP_NEXT, T_NONE};
      PC_W'(14): cw = '{OP_BYTE, SRC_CONST, 8'h80, W_1000_N4, JMP_END, T_NONE};
      // Write byte and set position share one step shape.
      PC_W'(15): cw = '{OP_BYTE, SRC_DATA,  8'h00, W_NONE,  JMP_END, T_NONE};
      PC_W'(16): cw = '{OP_BYTE, SRC_DATA,  8'h00, W_NONE,  JMP_END, T_NONE};
      default:   cw = '{OP_WAIT, SRC_CONST, 8'h00, W_NONE,  JMP_END, T_NONE};
    endcase
    return cw;
  endfunction

  // DDRAM base address of each display line.
  function automatic logic [7:0] line_base(input logic [1:0] line);
    logic [7:0] base;
    unique case (line)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

  // Extra wait selected by a microinstruction.
  function automatic logic [15:0] extra_wait(input wsel_e wsel, input logic bus8);
    logic [15:0] w;
    case (wsel)
      W_1000:    w = WAIT_1000;
      W_20000:   w = WAIT_20000;
      W_60000:   w = POWERUP_WAIT;
      W_1000_N4: w = bus8 ? 16'd0 : WAIT_1000;
      default:   w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/char_lcd_bus_sequencer.sv
// Channel   | Signals                              | Direction
// ----------+--------------------------------------+----------
// request   | in_valid_i, in_stall_o, in_data_i    | in
// event     | out_valid_o, out_stall_i, out_data_o | out
// config    | psel, penable, pwrite, paddr, pwdata | in (APB)
//
// A request expands into 0 to 17 events, one per cycle while the output is free.
// Init expands into 17 events on a four-bit bus and 10 on an eight-bit bus, a byte
// or position request into 2 or 1, and a reserved kind into none.
// A new request is taken while the final event still waits in the output register.
// Reset returns to idle with bus_8bit 0 and two_line 1.
// A stalled output holds the event and freezes the sequencer.
module char_lcd_bus_sequencer
  import clbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic            bus_8bit_q, two_line_q;
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            nib_q, nib_d;
  logic            rs_q, rs_d;
  logic [7:0]      data_q, data_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  ucode_t      cw;
  logic        in_fire, step_fire, step_final;
  logic [7:0]  src_byte;
  logic [15:0] ext;
  kind_e       kind;

  assign kind = kind_e'(in_data_i.kind);

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_8bit_q <= 1'b0;
      two_line_q <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_BUS_8BIT) begin
        bus_8bit_q <= pwdata[0];
      end else begin
        two_line_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TWO_LINE) begin
      prdata[0] = two_line_q;
    end else begin
      prdata[0] = bus_8bit_q;
    end
  end

  // Handshakes: one request at a time, a step runs when the output slot is free.
  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign step_fire  = busy_q && (!out_valid_q || !out_stall_i);

  // Datapath driven by the current control word.
  always_comb begin
    cw  = ucode(pc_q);
    ext = extra_wait(cw.wsel, bus_8bit_q);
    case (cw.src)
      SRC_DATA: src_byte = data_q;
      SRC_FSET: src_byte = bus_8bit_q ? 8'h38 : {4'h2, two_line_q, 3'b000};
      default:  src_byte = cw.konst;
    endcase

    out_d      = out_q;
    step_final = 1'b1;
    case (cw.op)
      OP_WAIT: begin
        out_d.strobe_res = 1'b0;
        out_d.rs_level   = 1'b0;
        out_d.bus_value  = 8'h00;
        out_d.wait_us    = ext;
      end
      OP_RAW: begin
        out_d.strobe_res = 1'b1;
        out_d.rs_level   = 1'b0;
        out_d.bus_value  = cw.konst;
        out_d.wait_us    = ext;
      end
      default: begin
        out_d.strobe_res = 1'b1;
        out_d.rs_level   = (cw.src == SRC_DATA) ? rs_q : 1'b0;
        if (bus_8bit_q) begin
          out_d.bus_value = src_byte;
          out_d.wait_us   = BYTE_WAIT + ext;
        end else if (!nib_q) begin
          out_d.bus_value = {src_byte[7:4], 4'h0};
          out_d.wait_us   = 16'd0;
          step_final      = 1'b0;
        end else begin
          out_d.bus_value = {src_byte[3:0], 4'h0};
          out_d.wait_us   = BYTE_WAIT + ext;
        end
      end
    endcase
    out_d.last = step_final && (cw.jmp == JMP_END);
    if (!step_fire) begin
      out_d = out_q;
    end
  end

  // Step counter, nibble phase and request capture.
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    nib_d       = nib_q;
    rs_d        = rs_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (step_fire) begin
      out_valid_d = 1'b1;
      if (!step_final) begin
        nib_d = 1'b1;
      end else begin
        nib_d = 1'b0;
        case (cw.jmp)
          JMP_END:    busy_d = 1'b0;
          JMP_ALWAYS: pc_d   = cw.target;
          JMP_IF8:    pc_d   = bus_8bit_q ? cw.target : pc_q + PC_W'(1);
          default:    pc_d   = pc_q + PC_W'(1);
        endcase
      end
    end

    if (in_fire) begin
      nib_d = 1'b0;
      unique case (kind)
        KIND_INIT: begin
          busy_d = 1'b1;
          pc_d   = PC_INIT;
          rs_d   = 1'b0;
        end
        KIND_WRITE: begin
          busy_d = 1'b1;
          pc_d   = PC_WRITE;
          rs_d   = in_data_i.register_select;
          data_d = in_data_i.byte_value;
        end
        KIND_POS: begin
          busy_d = 1'b1;
          pc_d   = PC_POS;
          rs_d   = 1'b0;
          data_d = line_base(in_data_i.line_index) + in_data_i.column + 8'hFF;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PC_INIT;
      nib_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    data_q <= data_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A real request starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (kind != KIND_RSVD) |=> busy_q)
    else $error("request accepted but sequencer not started");

  // The final step of a program stops the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && step_final && (cw.jmp == JMP_END) |=> !busy_q)
    else $error("sequencer kept running after the final event");

  // A pending low nibble only exists on the four-bit bus during a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nib_q |-> busy_q && !bus_8bit_q)
    else $error("low nibble pending outside a four-bit transfer");

  // The step counter stays inside the program while running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < PC_W'(PROG_LEN)))
    else $error("step counter left the program");

endmodule

>>> verif/char_lcd_bus_sequencer_tb.sv
module char_lcd_bus_sequencer_tb;
  import clbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register map of the configuration port.
  localparam logic [PADDR_W-1:0] ADDR_BUS_8BIT = PADDR_W'(4 * REG_BUS_8BIT);
  localparam logic [PADDR_W-1:0] ADDR_TWO_LINE = PADDR_W'(4 * REG_TWO_LINE);

  // LCD command bytes and hold-off times in microseconds.
  localparam logic [7:0]  CMD_WAKE       = 8'h30;
  localparam logic [7:0]  CMD_WAKE4      = 8'h20;
  localparam logic [7:0]  CMD_FSET4      = 8'h20;
  localparam logic [7:0]  FSET_TWO_LINE  = 8'h08;
  localparam logic [7:0]  CMD_FSET8      = 8'h38;
  localparam logic [7:0]  CMD_SHIFT      = 8'h14;
  localparam logic [7:0]  CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY      = 8'h06;
  localparam logic [7:0]  CMD_CLEAR      = 8'h01;
  localparam logic [7:0]  CMD_HOME       = 8'h80;
  localparam logic [15:0] US_NONE        = 16'd0;
  localparam logic [15:0] US_BYTE        = 16'd50;
  localparam logic [15:0] US_SHORT       = 16'd1000;
  localparam logic [15:0] US_WAKE        = 16'd20000;
  localparam logic [15:0] US_POWERUP     = 16'd60000;

  localparam int RANDOM_PER_PHASE = 62;
  localparam int SETTLE_CYCLES    = 24;
  localparam int END_CYCLES       = 40;
  localparam int LONG_HOLD        = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int NUM_MODES        = 4;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Requests waiting to be offered and LCD events still owed by the block.
  in_item_t  pending_requests[$];
  out_item_t lcd_events_due[$];

  // Mirror of the configuration registers.
  logic mode_bus8 = 1'b0;
  logic mode_two_line = 1'b1;

  int  err_cnt = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  free_left = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;

  logic [7:0] line_start[4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  char_lcd_bus_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One bus event with its hold-off; the final flag is set per request.
  function automatic void add_event(logic strobe, logic rs, logic [7:0] bus,
                                    logic [15:0] hold_us);
    out_item_t ev;
    ev.strobe_res = strobe;
    ev.rs_level   = rs;
    ev.bus_value  = bus;
    ev.wait_us    = hold_us;
    ev.last       = 1'b0;
    lcd_events_due.push_back(ev);
  endfunction

  // A whole byte on the eight-bit bus, else high nibble then low nibble.
  function automatic void add_byte(logic [7:0] val, logic rs, logic [15:0] extra_us);
    if (mode_bus8) begin
      add_event(1'b1, rs, val, US_BYTE + extra_us);
    end else begin
      add_event(1'b1, rs, {val[7:4], 4'h0}, US_NONE);
      add_event(1'b1, rs, {val[3:0], 4'h0}, US_BYTE + extra_us);
    end
  endfunction

  // Expands one accepted request into the events the LCD bus must see.
  function automatic void expand_request(in_item_t req);
    out_item_t tail;
    logic [7:0] addr;
    case (kind_e'(req.kind))
      KIND_INIT: begin
        add_event(1'b0, 1'b0, 8'h00, US_POWERUP);
        if (mode_bus8) begin
          add_byte(CMD_WAKE, 1'b0, US_WAKE);
          add_byte(CMD_WAKE, 1'b0, US_SHORT);
          add_byte(CMD_WAKE, 1'b0, US_NONE);
          add_byte(CMD_FSET8, 1'b0, US_NONE);
        end else begin
          add_event(1'b1, 1'b0, CMD_WAKE, US_WAKE);
          add_event(1'b1, 1'b0, CMD_WAKE, US_SHORT);
          add_event(1'b1, 1'b0, CMD_WAKE, US_NONE);
          add_event(1'b1, 1'b0, CMD_WAKE4, US_NONE);
          add_byte(mode_two_line ? (CMD_FSET4 | FSET_TWO_LINE) : CMD_FSET4, 1'b0, US_NONE);
        end
        add_byte(CMD_SHIFT, 1'b0, US_NONE);
        add_byte(CMD_DISPLAY_ON, 1'b0, US_NONE);
        add_byte(CMD_ENTRY, 1'b0, US_SHORT);
        add_byte(CMD_CLEAR, 1'b0, US_NONE);
        add_byte(CMD_HOME, 1'b0, mode_bus8 ? US_NONE : US_SHORT);
      end
      KIND_WRITE: begin
        add_byte(req.byte_value, req.register_select, US_NONE);
      end
      KIND_POS: begin
        addr = line_start[req.line_index] + req.column - 8'd1;
        add_byte(addr, 1'b0, US_NONE);
      end
      default: begin
        return;
      end
    endcase
    tail = lcd_events_due.pop_back();
    tail.last = 1'b1;
    lcd_events_due.push_back(tail);
  endfunction

  // Request transfers come in bursts with random gaps between them.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_request(in_data);
        void'(pending_requests.pop_front());
      end
      if (in_valid && in_stall) begin
        // The offered request stays on the channel unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_requests[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The event side alternates free runs and stall runs, with one long hold-off.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      free_left  = 0;
      hold_left  = 0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) begin
          stall_left = $urandom_range(1, 8);
        end else begin
          free_left = $urandom_range(0, 24);
        end
      end
    end
  end

  // Each event transfer is checked against the oldest event still owed.
  always @(posedge clk_i) begin : event_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_events_due.size() == 0) begin
        $error("event with no request behind it: %p", out_data);
        err_cnt++;
      end else begin
        want = lcd_events_due.pop_front();
        if (out_data.strobe_res !== want.strobe_res) begin
          $error("strobe_res: expected %0d, got %0d", want.strobe_res, out_data.strobe_res);
          err_cnt++;
        end
        if (out_data.rs_level !== want.rs_level) begin
          $error("rs_level: expected %0d, got %0d", want.rs_level, out_data.rs_level);
          err_cnt++;
        end
        if (out_data.bus_value !== want.bus_value) begin
          $error("bus_value: expected 0x%02h, got 0x%02h", want.bus_value, out_data.bus_value);
          err_cnt++;
        end
        if (out_data.wait_us !== want.wait_us) begin
          $error("wait_us: expected %0d, got %0d", want.wait_us, out_data.wait_us);
          err_cnt++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          err_cnt++;
        end
      end
    end
  end

  // The run ends if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic void queue_request(kind_e kind, logic rs, logic [7:0] val,
                                        logic [1:0] line, logic [7:0] col);
    in_item_t req;
    req.kind            = kind;
    req.register_select = rs;
    req.byte_value      = val;
    req.line_index      = line;
    req.column          = col;
    pending_requests.push_back(req);
  endfunction

  // Mostly byte writes and cursor moves, a few inits and some reserved kinds.
  function automatic in_item_t random_request();
    in_item_t req;
    int pick;
    req  = in_item_t'($bits(in_item_t)'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.kind = KIND_INIT;
    end else if (pick < 55) begin
      req.kind = KIND_WRITE;
    end else if (pick < 95) begin
      req.kind = KIND_POS;
    end else begin
      req.kind = KIND_RSVD;
    end
    return req;
  endfunction

  // Waits until every request is taken and every event has come, then settles.
  task automatic drain();
    while (pending_requests.size() != 0 || lcd_events_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(logic bus8, logic two_line);
    write_reg(ADDR_BUS_8BIT, {31'd0, bus8});
    write_reg(ADDR_TWO_LINE, {31'd0, two_line});
    mode_bus8     = bus8;
    mode_two_line = two_line;
  endtask

  // Reset, a directed pass in the reset mode, then random traffic per mode.
  initial begin
    logic bus8_of[NUM_MODES];
    logic two_of[NUM_MODES];
    in_item_t req;
    int count;

    bus8_of = '{1'b0, 1'b1, 1'b1, 1'b0};
    two_of  = '{1'b0, 1'b0, 1'b1, 1'b1};

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Field extremes, every kind, line bases and address wrap at both ends.
    queue_request(KIND_INIT, 1'b1, 8'hFF, 2'd3, 8'hFF);
    queue_request(KIND_WRITE, 1'b0, 8'h00, 2'd0, 8'h00);
    queue_request(KIND_WRITE, 1'b1, 8'hFF, 2'd3, 8'hFF);
    queue_request(KIND_WRITE, 1'b0, 8'hFF, 2'd1, 8'h55);
    queue_request(KIND_WRITE, 1'b1, 8'h00, 2'd2, 8'hAA);
    queue_request(KIND_WRITE, 1'b1, 8'hA5, 2'd0, 8'h0F);
    queue_request(KIND_WRITE, 1'b0, 8'h5A, 2'd0, 8'hF0);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd0, 8'd1);
    queue_request(KIND_POS, 1'b1, 8'hFF, 2'd1, 8'd1);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd2, 8'd1);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd3, 8'd1);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd0, 8'd0);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd3, 8'd0);
    queue_request(KIND_POS, 1'b1, 8'h00, 2'd1, 8'd255);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd2, 8'd255);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd3, 8'h2C);
    queue_request(KIND_POS, 1'b0, 8'h00, 2'd3, 8'h2D);
    queue_request(KIND_RSVD, 1'b1, 8'hFF, 2'd3, 8'hFF);
    queue_request(KIND_RSVD, 1'b0, 8'h00, 2'd0, 8'h00);
    queue_request(KIND_WRITE, 1'b1, 8'h3C, 2'd2, 8'h10);
    queue_request(KIND_INIT, 1'b0, 8'h00, 2'd0, 8'h00);
    drain();

    // Random traffic in the reset mode, then in each of the four modes in turn.
    for (int phase = 0; phase <= NUM_MODES; phase++) begin
      if (phase > 0) begin
        set_mode(bus8_of[phase-1], two_of[phase-1]);
        queue_request(KIND_INIT, 1'b0, 8'h00, 2'd0, 8'h00);
      end
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      count = 0;
      while (count < RANDOM_PER_PHASE) begin
        req = random_request();
        pending_requests.push_back(req);
        if (req.kind != KIND_RSVD) begin
          count++;
        end
      end
      drain();
    end

    repeat (END_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && lcd_events_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
